[rtl/ioq_pkg.sv]
// Shared types, command codes and the entry ordering rule for the order queue.
package ioq_pkg;

    localparam int IdW  = 10;
    localparam int PriW = 16;

    typedef struct packed {
        logic [IdW-1:0]  id;
        logic [PriW-1:0] pri;
        logic            tk;
        logic            dl;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry ent;
    } t_slot;

    localparam logic [2:0] CMD_HOLD  = 3'd0;
    localparam logic [2:0] CMD_INS   = 3'd1;
    localparam logic [2:0] CMD_POP   = 3'd2;
    localparam logic [2:0] CMD_REM   = 3'd3;
    localparam logic [2:0] CMD_SETDL = 3'd4;

    localparam logic [1:0] MODE_INS = 2'd0;
    localparam logic [1:0] MODE_POP = 2'd1;
    localparam logic [1:0] MODE_DLV = 2'd2;
    localparam logic [1:0] MODE_TKW = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // True when entry a is served before entry b.
    function automatic logic goes_before(input t_entry a, input t_entry b);
        logic r;
        if (a.pri != b.pri) begin
            r = a.pri < b.pri;
        end else if (a.tk != b.tk) begin
            r = a.tk;
        end else begin
            r = a.id < b.id;
        end
        return r;
    endfunction

endpackage

[rtl/indexed_order_priority_queue.sv]
// Top level of the order priority queue: command sequencer over a sorted row of cells.
//
// Usage: drive the four item fields and raise start; the beat is taken at a
// rising edge where start is high and busy is low. busy then stays high
// while the operation runs.
// Sequence: insert, pop and mark delivered pass through the lookup, execute
// and report steps of the sequencer; make takeaway adds a re-insertion step
// after execute, which puts the entry back after it is lifted out of the row.
// A new operation is taken only once the last one has reported and busy is low.
// Results: o_done is high for exactly one cycle and the result fields are
// valid in that cycle only. The receiver cannot stall the block.
// The entries are kept sorted in a row of CAPACITY cells; cell 0 holds the
// entry served next. Every cell shifts or loads together on the same clock edge.
// Reset: synchronous and active low; it empties the queue at once and
// returns the sequencer to idle, with no clearing pass.
module indexed_order_priority_queue #(
    parameter int CAPACITY = 64,
    parameter int ID_SPACE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [9:0]  i_order_id,
    input  logic [15:0] i_priority_req,
    input  logic        i_takeaway,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_top_valid,
    output logic [9:0]  o_top_id,
    output logic [9:0]  o_popped_id,
    output logic [15:0] o_popped_priority,
    output logic        o_popped_takeaway,
    output logic        o_popped_delivered,
    output logic [6:0]  o_occupancy
);
    import ioq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_REINS = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      r_mode;
    t_entry          r_req;
    logic            r_found;
    t_entry          r_hit;
    logic [1:0]      r_status, n_status;
    t_entry          r_pop, n_pop;

    logic [2:0]      cmd;
    t_entry          new_ent;
    t_slot           slots [CAPACITY];
    logic            b4 [CAPACITY];
    logic            match [CAPACITY];
    logic            found;
    t_entry          hit;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_slot prev_s, next_s;
            logic  prev_b;
            if (g == 0) begin : g_first
                assign prev_s = '0;
                assign prev_b = 1'b0;
            end else begin : g_mid
                assign prev_s = slots[g-1];
                assign prev_b = b4[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign next_s = '0;
            end else begin : g_inner
                assign next_s = slots[g+1];
            end
            ioq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (cmd),
                .i_new     (new_ent),
                .i_key     (r_req.id),
                .i_prev    (prev_s),
                .i_prev_b4 (prev_b),
                .i_next    (next_s),
                .o_slot    (slots[g]),
                .o_b4      (b4[g]),
                .o_match   (match[g])
            );
        end
    endgenerate

    always_comb begin
        found = 1'b0;
        hit   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            found = found | match[i];
            hit   = hit | (match[i] ? slots[i].ent : '0);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = r_status;
        n_pop    = r_pop;
        cmd      = CMD_HOLD;
        new_ent  = r_req;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state  = S_EXEC;
                n_status = ST_OK;
                n_pop    = '0;
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_mode)
                    MODE_INS: begin
                        if (32'(r_req.id) >= ID_SPACE) begin
                            n_status = ST_NOTFOUND;
                        end else if (r_count == CW'(CAPACITY) || r_found) begin
                            n_status = ST_FULL;
                        end else begin
                            cmd     = CMD_INS;
                            n_count = r_count + 1'b1;
                        end
                    end
                    MODE_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            cmd     = CMD_POP;
                            n_pop   = slots[0].ent;
                            n_count = r_count - 1'b1;
                        end
                    end
                    MODE_DLV: begin
                        if (!r_found) begin
                            n_status = ST_NOTFOUND;
                        end else begin
                            cmd = CMD_SETDL;
                        end
                    end
                    default: begin
                        if (!r_found) begin
                            n_status = ST_NOTFOUND;
                        end else begin
                            cmd     = CMD_REM;
                            new_ent = r_hit;
                            n_state = S_REINS;
                        end
                    end
                endcase
            end
            S_REINS: begin
                cmd        = CMD_INS;
                new_ent    = r_hit;
                new_ent.tk = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        if (r_state == S_IDLE && start) begin
            r_mode     <= i_mode;
            r_req.id   <= i_order_id;
            r_req.pri  <= i_priority_req;
            r_req.tk   <= i_takeaway;
            r_req.dl   <= 1'b0;
        end
        if (r_state == S_LOOK) begin
            r_found <= found;
            r_hit   <= hit;
        end
        r_status <= n_status;
        r_pop    <= n_pop;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_done             = (r_state == S_DONE);
    assign o_status           = r_status;
    assign o_top_valid        = slots[0].valid;
    assign o_top_id           = slots[0].valid ? slots[0].ent.id : '0;
    assign o_popped_id        = r_pop.id;
    assign o_popped_priority  = r_pop.pri;
    assign o_popped_takeaway  = r_pop.tk;
    assign o_popped_delivered = r_pop.dl;
    assign o_occupancy        = 7'(r_count);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("occupancy exceeds capacity");
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_REINS) |-> (slots[0].valid == (r_count != '0)))
        else $error("head cell disagrees with occupancy");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("sequencer did not return to idle after result");
`endif

endmodule

[rtl/ioq_cell.sv]
// One slot of the sorted row; it keeps, takes a neighbor's entry or the new one.
module ioq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [2:0]            i_cmd,
    input  ioq_pkg::t_entry       i_new,
    input  logic [ioq_pkg::IdW-1:0] i_key,
    input  ioq_pkg::t_slot        i_prev,
    input  logic                  i_prev_b4,
    input  ioq_pkg::t_slot        i_next,
    output ioq_pkg::t_slot        o_slot,
    output logic                  o_b4,
    output logic                  o_match
);
    import ioq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    assign o_slot  = r_slot;
    assign o_b4    = !r_slot.valid || goes_before(i_new, r_slot.ent);
    assign o_match = r_slot.valid && (r_slot.ent.id == i_key);

    always_comb begin
        n_slot = r_slot;
        unique case (i_cmd)
            CMD_INS: begin
                if (i_prev_b4) begin
                    n_slot = i_prev;
                end else if (o_b4) begin
                    n_slot.valid = 1'b1;
                    n_slot.ent   = i_new;
                end
            end
            CMD_POP: n_slot = i_next;
            CMD_REM: begin
                if (o_match || (r_slot.valid && goes_before(i_new, r_slot.ent))) begin
                    n_slot = i_next;
                end
            end
            CMD_SETDL: begin
                if (o_match) begin
                    n_slot.ent.dl = 1'b1;
                end
            end
            default: n_slot = r_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
            r_slot.ent   <= n_slot.ent;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule

[dv/tb_indexed_order_priority_queue.sv]
// Testbench for the indexed order priority queue: directed table, random phases, predictor.
module tb_indexed_order_priority_queue;
    import ioq_pkg::*;

    localparam int NUM_IDS   = 1024;
    localparam int MAX_HELD  = 64;
    localparam int N_RANDOM  = 1680;
    localparam int WDOG_MAX  = 4000;

    typedef struct {
        logic [1:0]  mode;
        logic [9:0]  id;
        logic [15:0] pri;
        logic        tk;
        bit          typed;
        logic [1:0]  st;
        logic        tv;
        logic [9:0]  top;
        logic [6:0]  occ;
    } t_row;

    typedef struct {
        logic [1:0]  st;
        logic        tv;
        logic [9:0]  top;
        logic [9:0]  pid;
        logic [15:0] ppri;
        logic        ptk;
        logic        pdl;
        logic [6:0]  occ;
        bit          typed;
        t_row        row;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [9:0]  i_order_id;
    logic [15:0] i_priority_req;
    logic        i_takeaway;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_top_valid;
    logic [9:0]  o_top_id;
    logic [9:0]  o_popped_id;
    logic [15:0] o_popped_priority;
    logic        o_popped_takeaway;
    logic        o_popped_delivered;
    logic [6:0]  o_occupancy;

    indexed_order_priority_queue i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_order_id         (i_order_id),
        .i_priority_req     (i_priority_req),
        .i_takeaway         (i_takeaway),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_top_valid        (o_top_valid),
        .o_top_id           (o_top_id),
        .o_popped_id        (o_popped_id),
        .o_popped_priority  (o_popped_priority),
        .o_popped_takeaway  (o_popped_takeaway),
        .o_popped_delivered (o_popped_delivered),
        .o_occupancy        (o_occupancy)
    );

    // Queue state as the predictor sees it, indexed by order id.
    bit          order_held [NUM_IDS];
    logic [15:0] order_pri  [NUM_IDS];
    logic        order_tk   [NUM_IDS];
    logic        order_dl   [NUM_IDS];
    int          held_ids   [$];
    t_result     pending_results [$];

    int  mismatches;
    int  results_seen;
    int  pops_seen;
    int  full_seen;
    int  idle_cycles;
    bit  timed_out;
    bit  quiet;

    function automatic bit serves_first(int a, int b);
        if (order_pri[a] != order_pri[b]) return order_pri[a] < order_pri[b];
        if (order_tk[a] != order_tk[b]) return order_tk[a];
        return a < b;
    endfunction

    function automatic int top_index();
        int best;
        best = 0;
        for (int k = 1; k < held_ids.size(); k++) begin
            if (serves_first(held_ids[k], held_ids[best])) best = k;
        end
        return best;
    endfunction

    function automatic t_result apply_order_op(t_row r);
        t_result res;
        int      idx;
        int      id;
        res = '{default: '0};
        id = int'(r.id);
        case (r.mode)
            MODE_INS: begin
                if (held_ids.size() >= MAX_HELD || order_held[id]) begin
                    res.st = ST_FULL;
                end else begin
                    order_held[id] = 1'b1;
                    order_pri[id]  = r.pri;
                    order_tk[id]   = r.tk;
                    order_dl[id]   = 1'b0;
                    held_ids.push_back(id);
                    res.st = ST_OK;
                end
            end
            MODE_POP: begin
                if (held_ids.size() == 0) begin
                    res.st = ST_EMPTY;
                end else begin
                    idx = top_index();
                    id = held_ids[idx];
                    held_ids.delete(idx);
                    order_held[id] = 1'b0;
                    res.st   = ST_OK;
                    res.pid  = 10'(id);
                    res.ppri = order_pri[id];
                    res.ptk  = order_tk[id];
                    res.pdl  = order_dl[id];
                end
            end
            default: begin
                if (!order_held[id]) begin
                    res.st = ST_NOTFOUND;
                end else begin
                    res.st = ST_OK;
                    if (r.mode == MODE_DLV) order_dl[id] = 1'b1;
                    else order_tk[id] = 1'b1;
                end
            end
        endcase
        res.tv  = held_ids.size() != 0;
        res.top = held_ids.size() != 0 ? 10'(held_ids[top_index()]) : 10'd0;
        res.occ = 7'(held_ids.size());
        res.typed = r.typed;
        res.row = r;
        return res;
    endfunction

    task automatic note_mismatch(string what, int exp_v, int act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
        end
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected beat, pending", 0, 1);
            end else begin
                e = pending_results.pop_front();
                if (o_status != e.st) note_mismatch("status", e.st, o_status);
                if (o_top_valid != e.tv) note_mismatch("top_valid", e.tv, o_top_valid);
                if (o_top_id != e.top) note_mismatch("top_id", e.top, o_top_id);
                if (o_popped_id != e.pid) note_mismatch("popped_id", e.pid, o_popped_id);
                if (o_popped_priority != e.ppri)
                    note_mismatch("popped_priority", e.ppri, o_popped_priority);
                if (o_popped_takeaway != e.ptk)
                    note_mismatch("popped_takeaway", e.ptk, o_popped_takeaway);
                if (o_popped_delivered != e.pdl)
                    note_mismatch("popped_delivered", e.pdl, o_popped_delivered);
                if (o_occupancy != e.occ) note_mismatch("occupancy", e.occ, o_occupancy);
                if (e.typed) begin
                    if (o_status != e.row.st) note_mismatch("table status", e.row.st, o_status);
                    if (o_top_valid != e.row.tv)
                        note_mismatch("table top_valid", e.row.tv, o_top_valid);
                    if (o_top_id != e.row.top) note_mismatch("table top_id", e.row.top, o_top_id);
                    if (o_occupancy != e.row.occ)
                        note_mismatch("table occupancy", e.row.occ, o_occupancy);
                end
                if (e.st == ST_OK && e.row.mode == MODE_POP) pops_seen++;
                if (e.st == ST_FULL) full_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired with %0d results pending", pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_beat(t_row r);
        t_result res;
        bit      taken;
        while (!quiet && $urandom_range(99) < 16) begin
            start <= 0;
            @(negedge i_clk);
        end
        start          <= 1;
        i_mode         <= r.mode;
        i_order_id     <= r.id;
        i_priority_req <= r.pri;
        i_takeaway     <= r.tk;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        res = apply_order_op(r);
        pending_results.push_back(res);
        @(negedge i_clk);
    endtask

    function automatic t_row random_row(bit filling);
        t_row r;
        int   pick;
        r = '{default: '0};
        pick = $urandom_range(99);
        if (filling) begin
            r.mode = pick < 70 ? MODE_INS : pick < 80 ? MODE_POP : pick < 90 ? MODE_DLV : MODE_TKW;
        end else begin
            r.mode = pick < 15 ? MODE_INS : pick < 80 ? MODE_POP : pick < 90 ? MODE_DLV : MODE_TKW;
        end
        r.id  = 10'($urandom_range(1023));
        r.pri = $urandom_range(1) ? 16'($urandom_range(7)) : 16'($urandom_range(65535));
        r.tk  = 1'($urandom_range(1));
        if (held_ids.size() != 0) begin
            if ((r.mode == MODE_INS && $urandom_range(99) < 15) ||
                (r.mode inside {MODE_DLV, MODE_TKW} && $urandom_range(99) < 80)) begin
                r.id = 10'(held_ids[$urandom_range(held_ids.size() - 1)]);
            end
        end
        return r;
    endfunction

    t_row directed_rows [20];

    initial begin
        bit filling;
        directed_rows = '{
            '{MODE_POP, 10'd0,    16'd0,     1'b0, 1, ST_EMPTY,    1'b0, 10'd0,    7'd0},
            '{MODE_DLV, 10'd5,    16'd0,     1'b0, 1, ST_NOTFOUND, 1'b0, 10'd0,    7'd0},
            '{MODE_TKW, 10'd1023, 16'd0,     1'b0, 1, ST_NOTFOUND, 1'b0, 10'd0,    7'd0},
            '{MODE_INS, 10'd1023, 16'd65535, 1'b1, 1, ST_OK,       1'b1, 10'd1023, 7'd1},
            '{MODE_INS, 10'd0,    16'd0,     1'b0, 1, ST_OK,       1'b1, 10'd0,    7'd2},
            '{MODE_INS, 10'd0,    16'd5,     1'b1, 1, ST_FULL,     1'b1, 10'd0,    7'd2},
            '{MODE_INS, 10'd7,    16'd0,     1'b1, 1, ST_OK,       1'b1, 10'd7,    7'd3},
            '{MODE_DLV, 10'd0,    16'd0,     1'b0, 1, ST_OK,       1'b1, 10'd7,    7'd3},
            '{MODE_TKW, 10'd0,    16'd0,     1'b0, 1, ST_OK,       1'b1, 10'd0,    7'd3},
            '{MODE_TKW, 10'd0,    16'd0,     1'b0, 1, ST_OK,       1'b1, 10'd0,    7'd3},
            '{MODE_POP, 10'd0,    16'd0,     1'b0, 1, ST_OK,       1'b1, 10'd7,    7'd2},
            '{MODE_INS, 10'd512,  16'd0,     1'b1, 0, ST_OK,       1'b0, 10'd0,    7'd0},
            '{MODE_INS, 10'd341,  16'd65535, 1'b0, 0, ST_OK,       1'b0, 10'd0,    7'd0},
            '{MODE_INS, 10'd682,  16'd32768, 1'b0, 0, ST_OK,       1'b0, 10'd0,    7'd0},
            '{MODE_TKW, 10'd341,  16'd0,     1'b0, 0, ST_OK,       1'b0, 10'd0,    7'd0},
            '{MODE_POP, 10'd0,    16'd0,     1'b0, 0, ST_OK,       1'b0, 10'd0,    7'd0},
            '{MODE_POP, 10'd0,    16'd0,     1'b0, 0, ST_OK,       1'b0, 10'd0,    7'd0},
            '{MODE_POP, 10'd0,    16'd0,     1'b0, 0, ST_OK,       1'b0, 10'd0,    7'd0},
            '{MODE_POP, 10'd0,    16'd0,     1'b0, 0, ST_OK,       1'b0, 10'd0,    7'd0},
            '{MODE_POP, 10'd0,    16'd0,     1'b0, 0, ST_OK,       1'b0, 10'd0,    7'd0}
        };
        i_rst_n = 0;
        start = 0;
        i_mode = MODE_INS;
        i_order_id = 0;
        i_priority_req = 0;
        i_takeaway = 0;
        mismatches = 0;
        results_seen = 0;
        pops_seen = 0;
        full_seen = 0;
        idle_cycles = 0;
        quiet = 0;
        filling = 1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        foreach (directed_rows[k]) send_beat(directed_rows[k]);

        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = n >= 500 && n < 800;
            if (n == 1000) begin
                start <= 0;
                while (pending_results.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            if (filling && held_ids.size() == MAX_HELD && $urandom_range(3) == 0) filling = 0;
            if (!filling && held_ids.size() <= 2) filling = 1;
            send_beat(random_row(filling));
        end
        start <= 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d beats: %0d pops, %0d rejected inserts, with idle gaps",
                 results_seen, pops_seen, full_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
